// ----- hdl/atsd_pkg.sv -----
// Shared constants and types for the accelerometer tap and shake detector.
`default_nettype none

package atsd_pkg;

    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 14;

    localparam int TAP_THR_W   = 14;
    localparam int SHAKE_THR_W = 13;
    localparam int HELD_W      = 4;

    localparam logic [TAP_THR_W-1:0]   TAP_THR_RST   = 14'd1000;
    localparam logic [SHAKE_THR_W-1:0] SHAKE_THR_RST = 13'd30;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_TAP_THR   = 1'b0,
        REG_SHAKE_THR = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic advance;
        logic write;
        logic sum_en;
        logic evict;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ----- hdl/atsd_sample_if.sv -----
// Input channel carrying one three-axis accelerometer sample per transaction.
`default_nettype none

interface atsd_sample_if
    import atsd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

`default_nettype wire

// ----- hdl/atsd_result_if.sv -----
// Output channel carrying the tap and shake flags for one sample per transaction.
`default_nettype none

interface atsd_result_if
    import atsd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              tap_seen;
    logic              shake_seen;
    logic [HELD_W-1:0] samples_held;

    modport source (output valid, output tap_seen, output shake_seen, output samples_held,
                    input ready);
    modport sink   (input valid, input tap_seen, input shake_seen, input samples_held,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/atsd_lane.sv -----
// One axis lane: sample window memory, running sum, deviation test and squared sum.
`default_nettype none

module atsd_lane
    import atsd_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire t_lane_ctl                                   i_ctl,
    input  wire logic [$clog2(WINDOW)-1:0]                   i_ptr,
    input  wire logic signed [SAMPLE_BITS-1:0]               i_sample,
    input  wire logic [TAP_THR_W+$clog2(WINDOW+1)-1:0]       i_tap_lim,
    output logic                                             o_dev,
    output logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]        o_sq
);

    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DEV_W  = SUM_W + 1;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int TLIM_W = TAP_THR_W + $clog2(WINDOW + 1);
    localparam int CMP_W  = (DEV_W > TLIM_W) ? DEV_W : TLIM_W;
    localparam logic signed [DEV_W-1:0] WIN_S = DEV_W'(WINDOW);

    logic signed [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_old;
    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic signed [SAMPLE_BITS-1:0] r_x2;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [SUM_W-1:0]       old_term;
    logic signed [DEV_W-1:0]       wx;
    logic signed [DEV_W-1:0]       diff;
    logic [DEV_W-1:0]              adiff;
    logic signed [SQ_W-1:0]        sq_s;
    logic                          r_dev;
    logic                          n_dev;
    logic [SQ_W-1:0]               r_sq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_mem[i_ptr] <= i_sample;
        end
        if (i_ctl.advance) begin
            r_old <= r_mem[i_ptr];
            r_x1  <= i_sample;
            r_x2  <= r_x1;
            r_dev <= n_dev;
            r_sq  <= $unsigned(sq_s);
        end
    end

    always_comb begin
        old_term = i_ctl.evict ? SUM_W'(r_old) : SUM_W'(0);
        n_sum    = r_sum + SUM_W'(r_x1) - old_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.sum_en) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        wx    = DEV_W'(r_x2) * WIN_S;
        diff  = wx - DEV_W'(r_sum);
        adiff = diff[DEV_W-1] ? $unsigned(-diff) : $unsigned(diff);
        n_dev = CMP_W'(adiff) > CMP_W'(i_tap_lim);
        sq_s  = SQ_W'(r_sum) * SQ_W'(r_sum);
    end

    assign o_dev = r_dev;
    assign o_sq  = r_sq;

endmodule

`default_nettype wire

// ----- hdl/atsd_merge.sv -----
// Merging stage that combines the three lane results into the registered output flags.
`default_nettype none

module atsd_merge
    import atsd_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_advance,
    input  wire logic [2:0]                                       i_dev,
    input  wire logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]        i_sq_x,
    input  wire logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]        i_sq_y,
    input  wire logic [2*(SAMPLE_BITS+$clog2(WINDOW))-1:0]        i_sq_z,
    input  wire logic                                             i_full,
    input  wire logic [$clog2(WINDOW+1)-1:0]                      i_cnt,
    input  wire logic [2*(SHAKE_THR_W+$clog2(WINDOW+1))-1:0]      i_lim_sq,
    output logic                                                  o_tap,
    output logic                                                  o_shake,
    output logic [HELD_W-1:0]                                     o_held
);

    localparam int SQ_W  = 2 * (SAMPLE_BITS + $clog2(WINDOW));
    localparam int MAG_W = SQ_W + 2;
    localparam int LSQ_W = 2 * (SHAKE_THR_W + $clog2(WINDOW + 1));
    localparam int CMP_W = (MAG_W > LSQ_W) ? MAG_W : LSQ_W;

    logic [MAG_W-1:0]  mag;
    logic              n_shake;
    logic              r_tap;
    logic              r_shake;
    logic [HELD_W-1:0] r_held;

    always_comb begin
        mag     = MAG_W'(i_sq_x) + MAG_W'(i_sq_y) + MAG_W'(i_sq_z);
        n_shake = CMP_W'(mag) > CMP_W'(i_lim_sq);
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_tap   <= i_full & (|i_dev);
            r_shake <= n_shake;
            r_held  <= HELD_W'(i_cnt);
        end
    end

    assign o_tap   = r_tap;
    assign o_shake = r_shake;
    assign o_held  = r_held;

endmodule

`default_nettype wire

// ----- hdl/accel_tap_shake_detector_top.sv -----
// Top level of the accelerometer tap and shake detector with its register port.
//
// One sample is accepted per clock cycle and its result passes through the r_v1, r_v2,
// r_v3 and r_vo registers; the whole pipeline holds while a finished result waits for the
// sink, so throughput is one sample per cycle whenever the sink takes results. Each axis
// lane keeps the last WINDOW samples in a small memory with one read and one write port,
// read at the window pointer; running sums update once per advancing cycle in the second
// stage. Tap is reported only once WINDOW samples are stored. The user must write the
// thresholds over the APB port while no transaction is in flight; it is not enforced.
`default_nettype none

module accel_tap_shake_detector_top
    import atsd_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    atsd_sample_if.sink                i_sample,
    atsd_result_if.source              o_result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SQ_W   = 2 * (SAMPLE_BITS + $clog2(WINDOW));
    localparam int TLIM_W = TAP_THR_W + $clog2(WINDOW + 1);
    localparam int LIM_W  = SHAKE_THR_W + CNT_W;
    localparam int LSQ_W  = 2 * LIM_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

    logic [TAP_THR_W-1:0]   r_tap_thr;
    logic [SHAKE_THR_W-1:0] r_shake_thr;
    logic [TLIM_W-1:0]      r_tap_lim;
    logic                   cfg_wr;

    logic               advance;
    logic               accept;
    logic [PTR_W-1:0]   r_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_vo;
    logic               r_evict1;
    logic [CNT_W-1:0]   r_cnt1;
    logic [CNT_W-1:0]   r_cnt2;
    logic [CNT_W-1:0]   r_cnt3;
    logic [LIM_W-1:0]   r_lim2;
    logic [LSQ_W-1:0]   r_lim_sq3;
    t_lane_ctl          lane_ctl;

    logic [2:0]         dev;
    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic [SQ_W-1:0]    sq_z;

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_thr   <= TAP_THR_RST;
            r_shake_thr <= SHAKE_THR_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[2]))
                REG_TAP_THR:   r_tap_thr   <= pwdata[TAP_THR_W-1:0];
                REG_SHAKE_THR: r_shake_thr <= pwdata[SHAKE_THR_W-1:0];
                default:       r_tap_thr   <= r_tap_thr;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_TAP_THR:   prdata = APB_DATA_W'(r_tap_thr);
            REG_SHAKE_THR: prdata = APB_DATA_W'(r_shake_thr);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tap_lim <= TLIM_W'(r_tap_thr) * TLIM_W'(WINDOW);
    end

    // Pipeline control.
    assign advance        = ~r_vo | o_result.ready;
    assign accept         = i_sample.valid & advance;
    assign i_sample.ready = advance;
    assign n_cnt          = (r_cnt == CNT_FULL) ? r_cnt : r_cnt + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_vo  <= 1'b0;
        end else begin
            if (accept) begin
                r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + PTR_W'(1);
                r_cnt <= n_cnt;
            end
            if (advance) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_evict1  <= (r_cnt == CNT_FULL);
            r_cnt1    <= n_cnt;
            r_cnt2    <= r_cnt1;
            r_cnt3    <= r_cnt2;
            r_lim2    <= LIM_W'(r_shake_thr) * LIM_W'(r_cnt1);
            r_lim_sq3 <= LSQ_W'(r_lim2) * LSQ_W'(r_lim2);
        end
    end

    always_comb begin
        lane_ctl.advance = advance;
        lane_ctl.write   = accept;
        lane_ctl.sum_en  = advance & r_v1;
        lane_ctl.evict   = r_evict1;
    end

    atsd_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_ptr     (r_ptr),
        .i_sample  (i_sample.accel_x),
        .i_tap_lim (r_tap_lim),
        .o_dev     (dev[0]),
        .o_sq      (sq_x)
    );

    atsd_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_ptr     (r_ptr),
        .i_sample  (i_sample.accel_y),
        .i_tap_lim (r_tap_lim),
        .o_dev     (dev[1]),
        .o_sq      (sq_y)
    );

    atsd_lane #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lane_ctl),
        .i_ptr     (r_ptr),
        .i_sample  (i_sample.accel_z),
        .i_tap_lim (r_tap_lim),
        .o_dev     (dev[2]),
        .o_sq      (sq_z)
    );

    atsd_merge #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .i_clk     (i_clk),
        .i_advance (advance),
        .i_dev     (dev),
        .i_sq_x    (sq_x),
        .i_sq_y    (sq_y),
        .i_sq_z    (sq_z),
        .i_full    (r_cnt3 == CNT_FULL),
        .i_cnt     (r_cnt3),
        .i_lim_sq  (r_lim_sq3),
        .o_tap     (o_result.tap_seen),
        .o_shake   (o_result.shake_seen),
        .o_held    (o_result.samples_held)
    );

    assign o_result.valid = r_vo;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("sample count exceeds the window length");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("window pointer out of range");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (r_cnt != CNT_FULL) |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("sample count did not advance on an accepted transaction");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_ptr) && $stable(r_cnt) && $stable(r_v3))
        else $error("pipeline state changed during a stall");

    a_out_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> r_cnt3 != '0)
        else $error("result in flight with an empty window");
`endif

endmodule

`default_nettype wire
